### sv/bca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap contiguous allocator.
// No dependencies.
package bca_pkg;

    // Request and result field widths
    localparam int KIND_W    = 1;
    localparam int CLUSTER_W = 13;
    localparam int LEN_W     = 13;
    localparam int STATUS_W  = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

    // Cluster numbers count from this offset
    localparam logic [CLUSTER_W-1:0] FIRST_NUMBER = 13'd2;

    // Word zero after reset: clusters 0..2 in use
    localparam logic [7:0] RESET_WORD0 = 8'd7;

endpackage

### sv/bca_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/bca_eval.sv
`timescale 1ns / 1ps
// Per-word first-fit evaluator: carries the free run across words and
// finds the first window of the requested length. Depends on bca_pkg.
module bca_eval import bca_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int RW        = 15,
    parameter int WA_W      = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_i,   // new scan, drop carried run
    input  logic                 valid_i,   // bitmap word present
    input  logic [WA_W-1:0]      word_i,
    input  logic [RW-1:0]        wbase_i,   // cluster index of bit 0
    input  logic [WORD_BITS-1:0] data_i,    // 1 = used
    input  logic [LEN_W-1:0]     len_i,
    output logic                 hit_o,
    output logic [RW-1:0]        hit_start_o,
    output logic [WA_W-1:0]      hit_word_o,
    output logic [RW-1:0]        hit_wbase_o
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int KI_W  = $clog2(CNT_W);
    localparam int BIT_W = $clog2(WORD_BITS);

    logic [RW-1:0]        carry_reg, carry_next;
    logic [RW-1:0]        rstart_reg, rstart_next;
    logic [WA_W-1:0]      rword_reg, rword_next;
    logic [RW-1:0]        rwbase_reg, rwbase_next;

    logic [WORD_BITS-1:0] free_bits;
    logic [CNT_W-1:0]     f0;       // free bits from bit 0 up
    logic [CNT_W-1:0]     l0;       // free bits from the top down
    logic [WORD_BITS-1:0] lvl [CNT_W];
    logic [KI_W-1:0]      k_msb;
    logic [CNT_W-1:0]     len_small;
    logic [CNT_W-1:0]     sh;
    logic [WORD_BITS-1:0] erode;
    logic [BIT_W-1:0]     jb;
    logic                 small_ok;
    logic                 hit_a;
    logic                 hit_b;

    assign len_small = len_i[CNT_W-1:0];
    assign small_ok  = (len_i <= LEN_W'(WORD_BITS));

    always_comb begin
        free_bits = ~data_i;
        f0 = CNT_W'(WORD_BITS);
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!free_bits[k]) f0 = CNT_W'(k);
        end
        l0 = CNT_W'(WORD_BITS);
        for (int k = 0; k < WORD_BITS; k++) begin
            if (!free_bits[k]) l0 = CNT_W'(WORD_BITS - 1 - k);
        end
        // lvl[i][j]: 2**i free bits end at j
        lvl[0] = free_bits;
        for (int i = 1; i < CNT_W; i++) begin
            lvl[i] = lvl[i-1] & (lvl[i-1] << (1 << (i - 1)));
        end
        k_msb = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (len_small[i]) k_msb = KI_W'(i);
        end
        // two overlapping power-of-two windows cover the length
        sh    = len_small - (CNT_W'(1) << k_msb);
        erode = lvl[k_msb] & (lvl[k_msb] << sh);
        jb = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (erode[k]) jb = BIT_W'(k);
        end
    end

    assign hit_a = (carry_reg + RW'(f0)) >= RW'(len_i);
    assign hit_b = small_ok && (|erode);
    assign hit_o = valid_i && (hit_a || hit_b);

    always_comb begin
        if (hit_a) begin
            hit_start_o = (carry_reg == '0) ? wbase_i : rstart_reg;
            hit_word_o  = (carry_reg == '0) ? word_i : rword_reg;
            hit_wbase_o = (carry_reg == '0) ? wbase_i : rwbase_reg;
        end else begin
            hit_start_o = wbase_i + RW'(jb) + RW'(1) - RW'(len_i);
            hit_word_o  = word_i;
            hit_wbase_o = wbase_i;
        end
    end

    always_comb begin
        carry_next  = carry_reg;
        rstart_next = rstart_reg;
        rword_next  = rword_reg;
        rwbase_next = rwbase_reg;
        if (start_i) begin
            carry_next = '0;
        end else if (valid_i && !(hit_a || hit_b)) begin
            if (f0 == CNT_W'(WORD_BITS)) begin
                if (carry_reg == '0) begin
                    rstart_next = wbase_i;
                    rword_next  = word_i;
                    rwbase_next = wbase_i;
                end
                carry_next = carry_reg + RW'(WORD_BITS);
            end else begin
                carry_next  = RW'(l0);
                rstart_next = wbase_i + RW'(WORD_BITS) - RW'(l0);
                rword_next  = word_i;
                rwbase_next = wbase_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
        end
        rstart_reg <= rstart_next;
        rword_reg  <= rword_next;
        rwbase_reg <= rwbase_next;
    end

endmodule

### sv/bitmap_contiguous_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit contiguous cluster allocator.
// Depends on bca_pkg, bca_ram, bca_eval.
//
//  channel | dir | handshake          | tdata                         | tuser
//  --------+-----+--------------------+-------------------------------+-------------
//  s_      | in  | s_tvalid/s_tready  | release_at, run_length        | kind
//  m_      | out | m_tvalid/m_tready  | granted_at                    | status
//
// Flow: one request at a time, one bitmap word per cycle; s_tready returns in the
// cycle after each result loads. Allocate: scans words until a run fits, then
// read-modify-writes the words of the run; a miss ends after the last word.
// Free: walks from word 0 to the last word of the run; a bad request goes straight to the result.
// Reset: clearing pass over every word (word 0 = clusters 0..2 used), s_tready low.
// Stalls: a result waits in the output register; the next request is still taken.
module bitmap_contiguous_allocator import bca_pkg::*; #(
    parameter int NUM_CLUSTERS = 4096,
    parameter int WORD_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request: tdata = release_at[12:0], run_length[25:13], zeros above
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    // result: tdata = granted_at[12:0], zeros above
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int NW        = (NUM_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NW > 1) ? $clog2(NW) : 1;
    localparam int WC_W      = $clog2(NW + 1);
    localparam int RW_A      = $clog2(NUM_CLUSTERS + WORD_BITS) + 1;
    localparam int RW        = (RW_A > 15) ? RW_A : 15;
    localparam int LAST_BITS = NUM_CLUSTERS - (NW - 1) * WORD_BITS;
    // bits of the last word beyond the bitmap read as used while scanning
    localparam logic [WORD_BITS-1:0] PAD_MASK =
        ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
    localparam logic [RW-1:0]   NC_R   = RW'(NUM_CLUSTERS);
    localparam logic [RW-1:0]   WB_R   = RW'(WORD_BITS);
    localparam logic [WC_W-1:0] NW_C   = WC_W'(NW);
    localparam logic [WC_W-1:0] NW_M1  = WC_W'(NW - 1);
    localparam logic [WA_W-1:0] LASTW  = WA_W'(NW - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [WA_W-1:0]      init_addr_reg, init_addr_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [RW-1:0]        run_start_reg, run_start_next;
    logic [RW-1:0]        run_end_reg, run_end_next;      // inclusive
    logic                 mod_set_reg, mod_set_next;      // 1 set, 0 clear
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [CLUSTER_W-1:0] res_start_reg, res_start_next;
    logic [WC_W-1:0]      rd_word_reg, rd_word_next;
    logic [RW-1:0]        rd_wbase_reg, rd_wbase_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rv_scan_reg, rv_scan_next;
    logic                 rv_mod_reg, rv_mod_next;
    logic [WA_W-1:0]      tag_word_reg, tag_word_next;
    logic [RW-1:0]        tag_wbase_reg, tag_wbase_next;
    logic [WORD_BITS-1:0] tag_mask_reg, tag_mask_next;
    logic                 tag_last_reg, tag_last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [CLUSTER_W-1:0] out_start_reg, out_start_next;

    // RAM ports
    logic                 ram_we;
    logic [WA_W-1:0]      ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WA_W-1:0]      ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // evaluator
    logic                 scan_start;
    logic                 eval_valid;
    logic [WORD_BITS-1:0] eval_data;
    logic                 hit;
    logic [RW-1:0]        hit_start;
    logic [WA_W-1:0]      hit_word;
    logic [RW-1:0]        hit_wbase;

    // request fields
    logic                 s_xfer;
    logic [CLUSTER_W-1:0] first_in;
    logic [LEN_W-1:0]     len_in;
    logic [RW-1:0]        fbase;
    logic [RW-1:0]        fend_x;   // exclusive end of a free

    // modify-phase word mask
    logic [RW-1:0]        mask_lo;
    logic [RW-1:0]        mask_hi;
    logic [WORD_BITS-1:0] mod_mask;
    logic                 mod_last;
    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign first_in = s_tdata[CLUSTER_W-1:0];
    assign len_in   = s_tdata[CLUSTER_W +: LEN_W];
    assign fbase    = RW'(first_in) - RW'(FIRST_NUMBER);
    assign fend_x   = fbase + RW'(len_in);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - CLUSTER_W){1'b0}}, out_start_reg};
    assign out_free = !out_valid_reg || m_tready;

    assign scan_start = s_xfer && (s_tuser == KIND_ALLOC) && (len_in != '0);
    assign eval_valid = rv_scan_reg && (state_reg == S_SCAN);
    assign eval_data  = tag_last_reg ? (ram_rdata | PAD_MASK) : ram_rdata;

    // mask of bits of the word at rd_wbase_reg that fall in the run
    always_comb begin
        mask_lo  = (run_start_reg > rd_wbase_reg) ? (run_start_reg - rd_wbase_reg) : '0;
        mask_hi  = run_end_reg - rd_wbase_reg;
        for (int k = 0; k < WORD_BITS; k++) begin
            mod_mask[k] = (RW'(k) >= mask_lo) && (RW'(k) <= mask_hi);
        end
        mod_last = (rd_wbase_reg + WB_R) > run_end_reg;
    end

    always_comb begin
        state_next      = state_reg;
        init_addr_next  = init_addr_reg;
        len_next        = len_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        mod_set_next    = mod_set_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        rd_word_next    = rd_word_reg;
        rd_wbase_next   = rd_wbase_reg;
        issue_done_next = issue_done_reg;
        rv_scan_next    = 1'b0;
        rv_mod_next     = 1'b0;
        tag_word_next   = tag_word_reg;
        tag_wbase_next  = tag_wbase_reg;
        tag_mask_next   = tag_mask_reg;
        tag_last_next   = tag_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        ram_we    = 1'b0;
        ram_waddr = tag_word_reg;
        ram_wdata = mod_set_reg ? (ram_rdata | tag_mask_reg) : (ram_rdata & ~tag_mask_reg);
        ram_re    = 1'b0;
        ram_raddr = rd_word_reg[WA_W-1:0];

        unique case (state_reg)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = init_addr_reg;
                ram_wdata = (init_addr_reg == '0) ? WORD_BITS'(RESET_WORD0) : '0;
                init_addr_next = init_addr_reg + WA_W'(1);
                if (init_addr_reg == LASTW) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_xfer) begin
                    len_next        = len_in;
                    res_start_next  = '0;
                    rd_word_next    = '0;
                    rd_wbase_next   = '0;
                    issue_done_next = 1'b0;
                    if (s_tuser == KIND_ALLOC) begin
                        mod_set_next = 1'b1;
                        if (len_in == '0) begin
                            res_status_next = ST_BAD;
                            state_next      = S_DONE;
                        end else begin
                            res_status_next = ST_DONE;
                            state_next      = S_SCAN;
                        end
                    end else begin
                        mod_set_next = 1'b0;
                        if (first_in < FIRST_NUMBER || len_in == '0 || fbase >= NC_R) begin
                            res_status_next = ST_BAD;
                            state_next      = S_DONE;
                        end else begin
                            // bits past the bitmap are left alone and flagged
                            res_status_next = (fend_x > NC_R) ? ST_BAD : ST_DONE;
                            run_start_next  = fbase;
                            run_end_next    = (fend_x > NC_R) ? (NC_R - RW'(1))
                                                              : (fend_x - RW'(1));
                            state_next      = S_MOD;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (rd_word_reg < NW_C) begin
                    ram_re         = 1'b1;
                    rv_scan_next   = 1'b1;
                    tag_word_next  = rd_word_reg[WA_W-1:0];
                    tag_wbase_next = rd_wbase_reg;
                    tag_last_next  = (rd_word_reg == NW_M1);
                    rd_word_next   = rd_word_reg + WC_W'(1);
                    rd_wbase_next  = rd_wbase_reg + WB_R;
                end
                if (hit) begin
                    run_start_next  = hit_start;
                    run_end_next    = hit_start + RW'(len_reg) - RW'(1);
                    res_start_next  = CLUSTER_W'(hit_start + RW'(FIRST_NUMBER));
                    rd_word_next    = WC_W'(hit_word);
                    rd_wbase_next   = hit_wbase;
                    issue_done_next = 1'b0;
                    state_next      = S_MOD;
                end else if (eval_valid && tag_last_reg) begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
            end

            S_MOD: begin
                // read word n+1 while word n is written back
                if (!issue_done_reg) begin
                    ram_re          = 1'b1;
                    rv_mod_next     = 1'b1;
                    tag_word_next   = rd_word_reg[WA_W-1:0];
                    tag_wbase_next  = rd_wbase_reg;
                    tag_mask_next   = mod_mask;
                    tag_last_next   = mod_last;
                    issue_done_next = mod_last;
                    rd_word_next    = rd_word_reg + WC_W'(1);
                    rd_wbase_next   = rd_wbase_reg + WB_R;
                end
                if (rv_mod_reg) begin
                    ram_we = 1'b1;
                    if (tag_last_reg) begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            init_addr_reg  <= '0;
            issue_done_reg <= 1'b0;
            rv_scan_reg    <= 1'b0;
            rv_mod_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_addr_reg  <= init_addr_next;
            issue_done_reg <= issue_done_next;
            rv_scan_reg    <= rv_scan_next;
            rv_mod_reg     <= rv_mod_next;
            out_valid_reg  <= out_valid_next;
        end
        len_reg        <= len_next;
        run_start_reg  <= run_start_next;
        run_end_reg    <= run_end_next;
        mod_set_reg    <= mod_set_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        rd_word_reg    <= rd_word_next;
        rd_wbase_reg   <= rd_wbase_next;
        tag_word_reg   <= tag_word_next;
        tag_wbase_reg  <= tag_wbase_next;
        tag_mask_reg   <= tag_mask_next;
        tag_last_reg   <= tag_last_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    bca_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bca_eval #(
        .WORD_BITS (WORD_BITS),
        .RW        (RW),
        .WA_W      (WA_W)
    ) u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (scan_start),
        .valid_i     (eval_valid),
        .word_i      (tag_word_reg),
        .wbase_i     (tag_wbase_reg),
        .data_i      (eval_data),
        .len_i       (len_reg),
        .hit_o       (hit),
        .hit_start_o (hit_start),
        .hit_word_o  (hit_word),
        .hit_wbase_o (hit_wbase)
    );

    // read-modify-write never reads the word it is writing
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap read and write hit the same word");

    // a run being marked stays inside the bitmap and is not empty
    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD) |-> (run_end_reg < NC_R && run_start_reg <= run_end_reg))
        else $error("run outside the bitmap");

    // write-back only for words up to the end of the run
    a_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_MOD) |-> (tag_wbase_reg <= run_end_reg))
        else $error("write-back past the end of the run");

    // a hit is only reported for a word being scanned
    a_hit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> (state_reg == S_SCAN && $past(ram_re)))
        else $error("hit outside a scan read");

    // failed or bad requests carry no start cluster
    a_fail_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata == '0))
        else $error("start cluster on a failed request");

endmodule
